>>> hdl/charlieplexed_seven_segment_driver_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the charlieplexed seven-segment driver
// Clocked on clk; the disabled forms are muted while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CHARLIEPLEXED_SEVEN_SEGMENT_DRIVER_MACROS_SVH
`define CHARLIEPLEXED_SEVEN_SEGMENT_DRIVER_MACROS_SVH

`ifndef ASSERT_OFF
`define CSSD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cssd assertion failed");
`define CSSD_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("cssd assertion failed");
`else
`define CSSD_ASSERT(label, prop)
`define CSSD_ASSERT_IMPL(label, pre, post)
`endif

`endif

>>> hdl/cssd_pkg.sv
// ---------------------------------------------------------------------------
// cssd_pkg
// Shared types, codes and segment patterns for the seven-segment driver.
// ---------------------------------------------------------------------------
package cssd_pkg;

  typedef enum logic [1:0] {
    FUNC_SHOW = 2'd0,
    FUNC_ALL  = 2'd1,
    FUNC_TICK = 2'd2
  } func_t;

  localparam logic [2:0] PHASE_LAST = 3'd4;

  localparam logic [4:0] PIN_A = 5'b00001;
  localparam logic [4:0] PIN_B = 5'b00010;
  localparam logic [4:0] PIN_C = 5'b00100;
  localparam logic [4:0] PIN_D = 5'b01000;
  localparam logic [4:0] PIN_E = 5'b10000;

  localparam logic [7:0] HUNDRED     = 8'd100;
  localparam logic [7:0] TWO_HUNDRED = 8'd200;

  typedef struct packed {
    logic [5:0] extra;
    logic [6:0] units;
    logic [6:0] tens;
  } seg_set_t;

  function automatic logic [6:0] digit_pattern(input logic [3:0] d);
    logic [6:0] p;
    case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = 7'h00;
    endcase
    return p;
  endfunction

endpackage

>>> hdl/cssd_digits.sv
// ---------------------------------------------------------------------------
// cssd_digits
// Split a number into hundreds, tens and units and build segment patterns.
// ---------------------------------------------------------------------------
module cssd_digits
  import cssd_pkg::*;
(
  input  logic [7:0] number,
  input  logic [3:0] icons,
  output seg_set_t   segs
);

  logic        hund_one;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [3:0]  units;
  logic [7:0]  rem_full;

  always_comb begin
    hund_one = (number >= HUNDRED) && (number < TWO_HUNDRED);
    if (number >= TWO_HUNDRED) begin
      rem_full = number - TWO_HUNDRED;
    end else if (number >= HUNDRED) begin
      rem_full = number - HUNDRED;
    end else begin
      rem_full = number;
    end
    rem       = rem_full[6:0];
    // divide by ten: multiply by 205, drop 11 bits (exact below 100)
    tens_prod = 15'(rem) * 15'd205;
    tens      = tens_prod[14:11];
    tens_x10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
    units     = 4'(rem - tens_x10);

    if (hund_one) begin
      segs.tens  = digit_pattern(4'd0);
      segs.units = digit_pattern(4'd0);
      segs.extra = {icons, 2'b11};
    end else begin
      segs.tens  = digit_pattern(tens);
      segs.units = digit_pattern(units);
      segs.extra = {icons, 2'b00};
    end
  end

endmodule

>>> hdl/charlieplexed_seven_segment_driver.sv
// ---------------------------------------------------------------------------
// charlieplexed_seven_segment_driver: five-pin scan of a 2.5 digit display
// One beat per cycle unless a tick waits behind a result that is not yet taken.
// Input register, then decode and scan select into the state and result regs.
// Synchronous active-low reset clears segments, scan phase and valids.
// ---------------------------------------------------------------------------
`include "charlieplexed_seven_segment_driver_macros.svh"

module charlieplexed_seven_segment_driver
  import cssd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_number,
  input  logic [3:0] in_icons,
  input  logic       in_all_on,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_pin_drive,
  output logic [4:0] out_pin_high,
  output logic [2:0] out_phase
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_func_r;
  logic [7:0] s1_number_r;
  logic [3:0] s1_icons_r;
  logic       s1_all_on_r;

  logic [6:0] tens_r, tens_nxt;
  logic [6:0] units_r, units_nxt;
  logic [5:0] extra_r, extra_nxt;
  logic [2:0] scan_phase_r, scan_phase_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [4:0] out_pin_drive_r, out_pin_drive_nxt;
  logic [4:0] out_pin_high_r, out_pin_high_nxt;
  logic [2:0] out_phase_r;

  logic       s1_is_tick;
  logic       s1_adv;
  logic       in_acc;
  seg_set_t   show_segs;

  cssd_digits u_digits (
    .number (s1_number_r),
    .icons  (s1_icons_r),
    .segs   (show_segs)
  );

  assign s1_is_tick = (s1_func_r == FUNC_TICK);
  assign s1_adv     = s1_valid_r && !(s1_is_tick && out_valid_r && !out_ready);
  assign in_ready   = !s1_valid_r || s1_adv;
  assign in_acc     = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // state update and scan select
  always_comb begin
    tens_nxt          = tens_r;
    units_nxt         = units_r;
    extra_nxt         = extra_r;
    scan_phase_nxt    = scan_phase_r;
    out_pin_drive_nxt = 5'd0;
    out_pin_high_nxt  = 5'd0;

    case (scan_phase_r)
      3'd0: begin
        if (tens_r[0]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_B;
        if (tens_r[1]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_D;
        if (tens_r[2]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_E;
        if (tens_r[5]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_C;
        out_pin_drive_nxt = out_pin_drive_nxt | PIN_A;
        out_pin_high_nxt  = PIN_A;
      end
      3'd1: begin
        if (units_r[0]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_C;
        if (units_r[3]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_E;
        if (units_r[4]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_A;
        if (units_r[5]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_D;
        out_pin_drive_nxt = out_pin_drive_nxt | PIN_B;
        out_pin_high_nxt  = PIN_B;
      end
      3'd2: begin
        if (extra_r[0]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_D;
        if (tens_r[4])  out_pin_drive_nxt = out_pin_drive_nxt | PIN_A;
        if (units_r[1]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_B;
        if (extra_r[2]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_E;
        out_pin_drive_nxt = out_pin_drive_nxt | PIN_C;
        out_pin_high_nxt  = PIN_C;
      end
      3'd3: begin
        if (extra_r[1]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_C;
        if (tens_r[6])  out_pin_drive_nxt = out_pin_drive_nxt | PIN_A;
        if (units_r[6]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_B;
        if (extra_r[5]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_E;
        out_pin_drive_nxt = out_pin_drive_nxt | PIN_D;
        out_pin_high_nxt  = PIN_D;
      end
      3'd4: begin
        if (tens_r[3])  out_pin_drive_nxt = out_pin_drive_nxt | PIN_A;
        if (units_r[2]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_B;
        if (extra_r[3]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_C;
        if (extra_r[4]) out_pin_drive_nxt = out_pin_drive_nxt | PIN_D;
        out_pin_drive_nxt = out_pin_drive_nxt | PIN_E;
        out_pin_high_nxt  = PIN_E;
      end
      default: begin
        out_pin_drive_nxt = 5'd0;
        out_pin_high_nxt  = 5'd0;
      end
    endcase

    if (s1_adv) begin
      case (s1_func_r)
        FUNC_SHOW: begin
          tens_nxt  = show_segs.tens;
          units_nxt = show_segs.units;
          extra_nxt = show_segs.extra;
        end
        FUNC_ALL: begin
          tens_nxt  = {7{s1_all_on_r}};
          units_nxt = {7{s1_all_on_r}};
          extra_nxt = {6{s1_all_on_r}};
        end
        FUNC_TICK: begin
          scan_phase_nxt = (scan_phase_r >= PHASE_LAST) ? 3'd0 : scan_phase_r + 3'd1;
        end
        default: begin
          scan_phase_nxt = scan_phase_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_is_tick) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      tens_r       <= 7'd0;
      units_r      <= 7'd0;
      extra_r      <= 6'd0;
      scan_phase_r <= 3'd0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      tens_r       <= tens_nxt;
      units_r      <= units_nxt;
      extra_r      <= extra_nxt;
      scan_phase_r <= scan_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r   <= in_func;
      s1_number_r <= in_number;
      s1_icons_r  <= in_icons;
      s1_all_on_r <= in_all_on;
    end
    if (s1_adv && s1_is_tick) begin
      out_pin_drive_r <= out_pin_drive_nxt;
      out_pin_high_r  <= out_pin_high_nxt;
      out_phase_r     <= scan_phase_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pin_drive = out_pin_drive_r;
  assign out_pin_high  = out_pin_high_r;
  assign out_phase     = out_phase_r;

  `CSSD_ASSERT(a_phase_range, scan_phase_r <= PHASE_LAST)
  `CSSD_ASSERT_IMPL(a_tick_result, s1_adv && s1_is_tick,
                    ##1 (out_valid_r && out_phase_r == $past(scan_phase_r)))
  `CSSD_ASSERT_IMPL(a_one_high, out_valid_r, $onehot(out_pin_high_r))
  `CSSD_ASSERT_IMPL(a_high_driven, out_valid_r, (out_pin_high_r & ~out_pin_drive_r) == 5'd0)

endmodule

>>> test/charlieplexed_seven_segment_driver_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// charlieplexed_seven_segment_driver_test: scan driver self-checking bench
// A directed table (reset, all-on, hundreds one, hundreds two, spare func)
// is followed by random command-then-scan runs mixed with noise. Typed rows
// carry their own expected scan; a display model predicts the rest, and
// results are compared field by field in order. Both sides idle at random,
// with one long output hold-off, one drain pause and one stretch without idling.
// ---------------------------------------------------------------------------
module charlieplexed_seven_segment_driver_test;
  import cssd_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int RANDOM_BEATS = 1200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PLAN_ROWS = 23;
  // digits 9..0, seven bits each
  localparam logic [69:0] GLYPHS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                    7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

  typedef struct packed {
    logic [4:0] drive;
    logic [4:0] high;
    logic [2:0] phase;
  } scan_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] number;
    logic [3:0] icons;
    logic       all_on;
    logic       typed;
    scan_t      want;
  } plan_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_func;
  logic [7:0] in_number;
  logic [3:0] in_icons;
  logic       in_all_on;
  logic       out_valid;
  logic       out_ready;
  logic [4:0] out_pin_drive;
  logic [4:0] out_pin_high;
  logic [2:0] out_phase;

  logic       row_typed;
  scan_t      row_want;

  logic [6:0] disp_tens;
  logic [6:0] disp_units;
  logic [5:0] disp_extra;
  logic [2:0] disp_phase;

  scan_t      scan_expected[$];
  plan_row_t  plan [PLAN_ROWS];

  int n_beats;
  int n_queued;
  int n_checked;
  int cycles;
  int n_ticks;
  int n_shows;
  int n_alls;
  int n_spare;
  int mismatches;
  int n_gen;
  bit burst_done;
  bit drained;
  int hold_left;

  charlieplexed_seven_segment_driver uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_number    (in_number),
    .in_icons     (in_icons),
    .in_all_on    (in_all_on),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pin_drive(out_pin_drive),
    .out_pin_high (out_pin_high),
    .out_phase    (out_phase)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [6:0] glyph(input logic [3:0] d);
    return GLYPHS[d * 7 +: 7];
  endfunction

  function automatic logic [7:0] pick_number();
    logic [7:0] n;
    case ($urandom_range(11))
      0: n = 8'd0;
      1: n = 8'd99;
      2: n = 8'd100;
      3: n = 8'd199;
      4: n = 8'd200;
      5: n = 8'd255;
      default: n = 8'($urandom_range(255));
    endcase
    return n;
  endfunction

  function automatic bit calm();
    return n_beats >= 500 && n_beats < 700;
  endfunction

  task automatic advance_display(input logic [1:0] f, input logic [7:0] n,
                                 input logic [3:0] ic, input logic on,
                                 output bit makes, output scan_t r);
    logic [3:0] hund;
    logic [3:0] te;
    logic [3:0] un;
    logic [5:0] e;
    makes = 1'b0;
    r = '0;
    case (f)
      FUNC_SHOW: begin
        hund = 4'(n / 8'd100);
        te = 4'((n % 8'd100) / 8'd10);
        un = 4'(n % 8'd10);
        e = '0;
        if (hund == 4'd1) begin
          te = '0;
          un = '0;
          e = 6'h03;
        end
        disp_tens = glyph(te);
        disp_units = glyph(un);
        disp_extra = e | {ic, 2'b00};
      end
      FUNC_ALL: begin
        disp_tens = {7{on}};
        disp_units = {7{on}};
        disp_extra = {6{on}};
      end
      FUNC_TICK: begin
        makes = 1'b1;
        r.phase = disp_phase;
        case (disp_phase)
          3'd0: begin
            r.drive = PIN_A | (disp_tens[0] ? PIN_B : '0) | (disp_tens[1] ? PIN_D : '0)
                    | (disp_tens[2] ? PIN_E : '0) | (disp_tens[5] ? PIN_C : '0);
            r.high = PIN_A;
          end
          3'd1: begin
            r.drive = PIN_B | (disp_units[0] ? PIN_C : '0) | (disp_units[3] ? PIN_E : '0)
                    | (disp_units[4] ? PIN_A : '0) | (disp_units[5] ? PIN_D : '0);
            r.high = PIN_B;
          end
          3'd2: begin
            r.drive = PIN_C | (disp_extra[0] ? PIN_D : '0) | (disp_tens[4] ? PIN_A : '0)
                    | (disp_units[1] ? PIN_B : '0) | (disp_extra[2] ? PIN_E : '0);
            r.high = PIN_C;
          end
          3'd3: begin
            r.drive = PIN_D | (disp_extra[1] ? PIN_C : '0) | (disp_tens[6] ? PIN_A : '0)
                    | (disp_units[6] ? PIN_B : '0) | (disp_extra[5] ? PIN_E : '0);
            r.high = PIN_D;
          end
          3'd4: begin
            r.drive = PIN_E | (disp_tens[3] ? PIN_A : '0) | (disp_units[2] ? PIN_B : '0)
                    | (disp_extra[3] ? PIN_C : '0) | (disp_extra[4] ? PIN_D : '0);
            r.high = PIN_E;
          end
          default: begin
            r.drive = '0;
            r.high = '0;
          end
        endcase
        disp_phase = (disp_phase >= PHASE_LAST) ? 3'd0 : disp_phase + 3'd1;
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  // track accepted beats and predict scan results
  always @(posedge clk) begin : predict_beats
    bit makes;
    scan_t r;
    if (rst_n && in_valid && in_ready) begin
      n_beats <= n_beats + 1;
      advance_display(in_func, in_number, in_icons, in_all_on, makes, r);
      case (in_func)
        FUNC_SHOW: n_shows++;
        FUNC_ALL:  n_alls++;
        FUNC_TICK: n_ticks++;
        default:   n_spare++;
      endcase
      if (makes) begin
        scan_expected.push_back(row_typed ? row_want : r);
        n_queued <= n_queued + 1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    scan_t w;
    if (rst_n && out_valid && out_ready) begin
      n_checked <= n_checked + 1;
      if (scan_expected.size() == 0) begin
        note_mismatch("unexpected result, phase", -1, out_phase);
      end else begin
        w = scan_expected.pop_front();
        if (out_pin_drive !== w.drive) note_mismatch("pin_drive", w.drive, out_pin_drive);
        if (out_pin_high !== w.high) note_mismatch("pin_high", w.high, out_pin_high);
        if (out_phase !== w.phase) note_mismatch("phase", w.phase, out_phase);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off, calm stretch
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!burst_done && n_beats >= 300) begin
        hold_left = 150;
        burst_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm()) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 11);
      end
    end
  end

  task automatic rest();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic present(input logic [1:0] f, input logic [7:0] n, input logic [3:0] ic,
                         input logic on, input logic typed, input scan_t want);
    in_valid <= 1'b1;
    in_func <= f;
    in_number <= n;
    in_icons <= ic;
    in_all_on <= on;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic present_random(input logic [1:0] f, input logic [7:0] n,
                                input logic [3:0] ic, input logic on);
    if (!calm() && $urandom_range(99) < 11) rest();
    present(f, n, ic, on, 1'b0, '0);
    if (f != FUNC_SPARE) n_gen++;
  endtask

  task automatic drain();
    rest();
    while (n_queued != n_checked) rest();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= FUNC_SHOW;
    in_number <= '0;
    in_icons <= '0;
    in_all_on <= 1'b0;
    row_typed <= 1'b0;
    row_want <= '0;
    disp_tens = '0;
    disp_units = '0;
    disp_extra = '0;
    disp_phase = '0;

    plan[0]  = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b1, PIN_A, PIN_A, 3'd0};
    plan[1]  = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b1, PIN_B, PIN_B, 3'd1};
    plan[2]  = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b1, PIN_C, PIN_C, 3'd2};
    plan[3]  = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b1, PIN_D, PIN_D, 3'd3};
    plan[4]  = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b1, PIN_E, PIN_E, 3'd4};
    plan[5]  = {FUNC_ALL,   8'd0,   4'h0, 1'b1, 1'b0, 13'd0};
    plan[6]  = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b1, 5'h1F, PIN_A, 3'd0};
    plan[7]  = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b1, 5'h1F, PIN_B, 3'd1};
    plan[8]  = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b1, 5'h1F, PIN_C, 3'd2};
    plan[9]  = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b1, 5'h1F, PIN_D, 3'd3};
    plan[10] = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b1, 5'h1F, PIN_E, 3'd4};
    plan[11] = {FUNC_ALL,   8'hFF,  4'hF, 1'b0, 1'b0, 13'd0};
    plan[12] = {FUNC_SHOW,  8'd100, 4'h0, 1'b0, 1'b0, 13'd0};
    plan[13] = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b0, 13'd0};
    plan[14] = {FUNC_SHOW,  8'd199, 4'hF, 1'b1, 1'b0, 13'd0};
    plan[15] = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b0, 13'd0};
    plan[16] = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b0, 13'd0};
    plan[17] = {FUNC_SHOW,  8'd200, 4'h5, 1'b0, 1'b0, 13'd0};
    plan[18] = {FUNC_TICK,  8'hFF,  4'hF, 1'b1, 1'b0, 13'd0};
    plan[19] = {FUNC_SHOW,  8'd255, 4'hA, 1'b0, 1'b0, 13'd0};
    plan[20] = {FUNC_SPARE, 8'hFF,  4'hF, 1'b1, 1'b0, 13'd0};
    plan[21] = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b0, 13'd0};
    plan[22] = {FUNC_TICK,  8'd0,   4'h0, 1'b0, 1'b0, 13'd0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < PLAN_ROWS; k++)
      present(plan[k].func, plan[k].number, plan[k].icons, plan[k].all_on,
              plan[k].typed, plan[k].want);

    while (n_gen < RANDOM_BEATS) begin
      if (!drained && n_gen >= 900) begin
        drain();
        drained = 1'b1;
      end
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(3) == 0)
          present_random(FUNC_ALL, 8'($urandom_range(255)), 4'($urandom_range(15)),
                         1'($urandom_range(1)));
        else
          present_random(FUNC_SHOW, pick_number(), 4'($urandom_range(15)),
                         1'($urandom_range(1)));
        repeat ($urandom_range(1, 7))
          present_random(FUNC_TICK, 8'($urandom_range(255)), 4'($urandom_range(15)),
                         1'($urandom_range(1)));
      end else begin
        present_random(2'($urandom_range(3)), pick_number(), 4'($urandom_range(15)),
                       1'($urandom_range(1)));
      end
    end

    drain();
    repeat (10) rest();

    $display("covered %0d beats: %0d scan ticks, %0d shows, %0d all on/off, %0d spare",
             n_beats, n_ticks, n_shows, n_alls, n_spare);
    $display("checked %0d scan results, %0d mismatches, %0d left over",
             n_checked, mismatches, scan_expected.size());
    if (mismatches == 0 && scan_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
